/* design/ptdc_pkg.sv */
// ----------------------------------------------------------------------------
// ptdc_pkg
// Shared types, constants, tables and fixed-point helpers of the drive
// controller.
// ----------------------------------------------------------------------------
package ptdc_pkg;

    localparam int PATH_LEN     = 1024;
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_STEPS    = 64;
    localparam int DIV_CW       = $clog2(DIV_STEPS + 1);

    localparam logic [9:0] IDX_LAST = 10'((PATH_LEN - 1) < 1023 ? (PATH_LEN - 1) : 1023);

    localparam logic signed [33:0] CORDIC_K   = 34'sd652032874;
    localparam logic signed [33:0] TWO_PI_Q16 = 34'sd411775;

    localparam logic signed [33:0] ATAN_TAB [24] = '{
        34'sh020000000, 34'sh012E4051E, 34'sh009FB385B, 34'sh0051111D4,
        34'sh0028B0D43, 34'sh00145D7E1, 34'sh000A2F61E, 34'sh000517C55,
        34'sh00028BE53, 34'sh000145F2F, 34'sh0000A2F98, 34'sh0000517CC,
        34'sh000028BE6, 34'sh0000145F3, 34'sh00000A2FA, 34'sh00000517D,
        34'sh0000028BE, 34'sh00000145F, 34'sh000000A30, 34'sh000000518,
        34'sh00000028C, 34'sh000000146, 34'sh0000000A3, 34'sh000000051
    };

    typedef enum logic [2:0] {
        CFG_LINEAR_SPEED,
        CFG_WHEEL_BASE,
        CFG_WHEEL_RADIUS,
        CFG_LAT_KP,
        CFG_LAT_KI,
        CFG_LAT_KD,
        CFG_HEADING_KP,
        CFG_ARRIVE_DIST
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_CORD, S_DXS, S_DYC, S_ELAT, S_EANG, S_PT, S_KI, S_ALO, S_AHI,
        S_INC, S_HT, S_KD, S_DIVD, S_WSAT, S_LW, S_LWC, S_DIVL, S_RST, S_DIVR,
        S_UX, S_UY, S_AD, S_ADV, S_OUT
    } t_state;

    function automatic logic signed [67:0] rnd16(input logic signed [67:0] v);
        return (v + 68'sd32768) >>> 16;
    endfunction

    function automatic logic ovf32(input logic signed [67:0] v);
        return (v > 68'sd2147483647) || (v < -68'sd2147483648);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -68'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

/* design/ptdc_mul.sv */
// ----------------------------------------------------------------------------
// ptdc_mul
// Shared signed 34 x 34 multiplier with a registered product.
// ----------------------------------------------------------------------------
module ptdc_mul
    import ptdc_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [33:0] i_a,
    input  logic signed [33:0] i_b,
    output logic signed [67:0] o_p
);

    logic signed [67:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

/* design/ptdc_cordic.sv */
// ----------------------------------------------------------------------------
// ptdc_cordic
// Iterative rotation CORDIC: sine and cosine of a binary angle, signed 20-bit with 16 fraction bits (Q3.16).
// ----------------------------------------------------------------------------
module ptdc_cordic
    import ptdc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_yaw,
    output logic               o_done,
    output logic signed [19:0] o_sin,
    output logic signed [19:0] o_cos
);

    logic signed [33:0] r_x, r_y, r_z;
    logic [4:0]         r_i;
    logic               r_busy, r_done, r_flip;
    logic               flip;
    logic signed [15:0] a16;
    logic signed [33:0] shx, shy, xr, yr;

    assign flip = i_yaw[15] ^ i_yaw[14];
    assign a16  = flip ? (i_yaw ^ 16'h8000) : i_yaw;
    assign shx  = r_x >>> r_i;
    assign shy  = r_y >>> r_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_flip <= flip;
                r_x    <= CORDIC_K;
                r_y    <= '0;
                r_z    <= 34'(signed'({a16, 16'h0000}));
            end else if (r_busy) begin
                if (!r_z[33]) begin
                    r_x <= r_x - shy;
                    r_y <= r_y + shx;
                    r_z <= r_z - ATAN_TAB[r_i];
                end else begin
                    r_x <= r_x + shy;
                    r_y <= r_y - shx;
                    r_z <= r_z + ATAN_TAB[r_i];
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign xr     = (r_x + 34'sd8192) >>> 14;
    assign yr     = (r_y + 34'sd8192) >>> 14;
    assign o_cos  = r_flip ? -xr[19:0] : xr[19:0];
    assign o_sin  = r_flip ? -yr[19:0] : yr[19:0];
    assign o_done = r_done;

endmodule

/* design/ptdc_div.sv */
// ----------------------------------------------------------------------------
// ptdc_div
// Restoring signed divider, one quotient bit per cycle, truncating toward
// zero.
// ----------------------------------------------------------------------------
module ptdc_div
    import ptdc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic [31:0]        i_den,
    output logic               o_done,
    output logic signed [64:0] o_quo
);

    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy, r_done, r_neg;
    logic [31:0]       r_rem, r_den;
    logic [63:0]       r_q;
    logic [32:0]       trial;
    logic              ge;
    logic [64:0]       mag;

    assign trial = {r_rem, r_q[63]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_STEPS);
                r_rem  <= '0;
                r_den  <= i_den;
                r_neg  <= i_num[63];
                r_q    <= i_num[63] ? 64'(-i_num) : 64'(i_num);
            end else if (r_busy) begin
                r_rem <= ge ? 32'(trial - {1'b0, r_den}) : trial[31:0];
                r_q   <= {r_q[62:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign mag    = {1'b0, r_q};
    assign o_quo  = r_neg ? -mag : mag;
    assign o_done = r_done;

endmodule

/* design/path_tracking_drive_controller_unit.sv */
// ----------------------------------------------------------------------------
// path_tracking_drive_controller_unit
// Lateral PID with heading term for a differential-drive robot.
//
// Requests arrive on the slave stream: tuser bit 0 selects a control tick
// (0) or a start (1), tdata carries pose, target waypoint, elapsed time and
// start index. Each request yields one result on the master stream: both
// wheel speeds, the waypoint index to track next, arrival and clip flags.
// Configuration registers are written over the cfg channel, which is always
// ready; write them only while the block is idle.
// A start request presents its result in the cycle after acceptance. A control
// tick runs a 16-step CORDIC, thirteen passes through the one shared
// multiplier and three runs of the bit-serial divider (derivative term and
// the two wheel speeds) before its result is presented. One request is in
// work at a time; s_tready is low from acceptance until the result is taken.
// A stalled master side holds the result in its output register.
// Reset restores the register defaults, clears the integral and sets the
// waypoint index to zero.
// ----------------------------------------------------------------------------
module path_tracking_drive_controller_unit
    import ptdc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // pose_x, pose_y, pose_yaw, target_x, target_y, target_yaw, elapsed,
    // start_index, zero pad
    input  logic [191:0] i_s_tdata,
    // op
    input  logic [0:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // left_wheel, right_wheel, waypoint_index, advanced, saturated, zero pad
    output logic [79:0]  o_m_tdata
);

    t_state r_state, n_state;

    logic signed [31:0] r_lin_speed, r_lat_kp, r_lat_ki, r_lat_kd, r_heading_kp;
    logic [30:0]        r_wheel_base, r_wheel_radius, r_arrive_dist;

    logic signed [31:0] r_integral;
    logic [9:0]         r_index;

    logic signed [32:0] r_dx, r_dy;
    logic signed [15:0] r_eyaw;
    logic [15:0]        r_el;
    logic signed [31:0] r_elat, r_wsat, r_left, r_right;
    logic signed [67:0] r_eang, r_acc, r_w;
    logic signed [47:0] r_a;
    logic               r_adv, r_sat;

    logic               s_acc;
    logic signed [31:0] s_px, s_py, s_tx, s_ty;
    logic [15:0]        s_pyaw, s_tyaw, s_el;
    logic [9:0]         s_sidx;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod, pr16, elat_full, inc, isum, wsum;
    logic               cord_start, cord_done;
    logic signed [19:0] sin_v, cos_v;
    logic               div_start, div_done;
    logic signed [63:0] div_num, twov;
    logic [31:0]        div_den, r2;
    logic signed [64:0] quo;
    logic [32:0]        ux, uy;
    logic               far;

    assign s_acc  = i_s_tvalid && o_s_tready;
    assign s_px   = i_s_tdata[31:0];
    assign s_py   = i_s_tdata[63:32];
    assign s_pyaw = i_s_tdata[79:64];
    assign s_tx   = i_s_tdata[111:80];
    assign s_ty   = i_s_tdata[143:112];
    assign s_tyaw = i_s_tdata[159:144];
    assign s_el   = i_s_tdata[175:160];
    assign s_sidx = i_s_tdata[185:176];

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = (r_state == S_OUT);
    assign o_m_tdata   = {4'd0, r_sat, r_adv, r_index, r_right, r_left};

    ptdc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    ptdc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_yaw   (s_tyaw),
        .o_done  (cord_done),
        .o_sin   (sin_v),
        .o_cos   (cos_v)
    );

    ptdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    assign pr16      = rnd16(prod);
    assign elat_full = rnd16(r_acc - prod);
    assign inc       = rnd16((prod <<< 24) + r_acc);
    assign isum      = 68'(r_integral) + inc;
    assign wsum      = r_w + (68'(r_integral) <<< 1) - 68'(quo);
    assign twov      = 64'(r_lin_speed) <<< 17;
    assign r2        = {(r_wheel_radius == '0) ? 31'd1 : r_wheel_radius, 1'b0};
    assign ux        = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign uy        = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
    assign far       = ux[32] | ux[31] | uy[32] | uy[31];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_acc) n_state = i_s_tuser[0] ? S_OUT : S_CORD;
            S_CORD: if (cord_done) n_state = S_DXS;
            S_DXS:  n_state = S_DYC;
            S_DYC:  n_state = S_ELAT;
            S_ELAT: n_state = S_EANG;
            S_EANG: n_state = S_PT;
            S_PT:   n_state = S_KI;
            S_KI:   n_state = S_ALO;
            S_ALO:  n_state = S_AHI;
            S_AHI:  n_state = S_INC;
            S_INC:  n_state = S_HT;
            S_HT:   n_state = S_KD;
            S_KD:   n_state = S_DIVD;
            S_DIVD: if (div_done) n_state = S_WSAT;
            S_WSAT: n_state = S_LW;
            S_LW:   n_state = S_LWC;
            S_LWC:  n_state = S_DIVL;
            S_DIVL: if (div_done) n_state = S_RST;
            S_RST:  n_state = S_DIVR;
            S_DIVR: if (div_done) n_state = S_UX;
            S_UX:   n_state = S_UY;
            S_UY:   n_state = S_AD;
            S_AD:   n_state = S_ADV;
            S_ADV:  n_state = S_OUT;
            S_OUT:  if (i_m_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = r2;
        cord_start = 1'b0;
        unique case (r_state)
            S_IDLE: cord_start = s_acc && !i_s_tuser[0];
            S_DXS:  begin mul_a = 34'(r_dx); mul_b = 34'(sin_v); end
            S_DYC:  begin mul_a = 34'(r_dy); mul_b = 34'(cos_v); end
            S_ELAT: begin mul_a = 34'(r_eyaw); mul_b = TWO_PI_Q16; end
            S_EANG: begin mul_a = 34'(r_lat_kp); mul_b = 34'(r_elat); end
            S_PT:   begin mul_a = 34'(r_lat_ki); mul_b = 34'(r_elat); end
            S_ALO:  begin mul_a = 34'(r_a[23:0]); mul_b = 34'(r_el); end
            S_AHI:  begin mul_a = 34'(signed'(r_a[47:24])); mul_b = 34'(r_el); end
            S_INC:  begin mul_a = 34'(r_heading_kp); mul_b = r_eang[33:0]; end
            S_HT:   begin mul_a = 34'(r_lat_kd); mul_b = 34'(r_elat); end
            S_KD: begin
                div_start = 1'b1;
                div_num   = prod[63:0];
                div_den   = 32'(r_el);
            end
            S_LW:   begin mul_a = 34'(r_wheel_base); mul_b = 34'(r_wsat); end
            S_LWC:  begin div_start = 1'b1; div_num = twov + prod[63:0]; end
            S_RST:  begin div_start = 1'b1; div_num = twov - r_acc[63:0]; end
            S_UX:   begin mul_a = 34'(ux[30:0]); mul_b = 34'(ux[30:0]); end
            S_UY:   begin mul_a = 34'(uy[30:0]); mul_b = 34'(uy[30:0]); end
            S_AD:   begin mul_a = 34'(r_arrive_dist); mul_b = 34'(r_arrive_dist); end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_speed    <= 32'sd0;
            r_wheel_base   <= 31'd0;
            r_wheel_radius <= 31'd65536;
            r_lat_kp       <= -32'sd131072;
            r_lat_ki       <= -32'sd6554;
            r_lat_kd       <= -32'sd3277;
            r_heading_kp   <= 32'sd111411;
            r_arrive_dist  <= 31'd26214;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LINEAR_SPEED: r_lin_speed    <= i_cfg_data;
                CFG_WHEEL_BASE:   r_wheel_base   <= i_cfg_data[30:0];
                CFG_WHEEL_RADIUS: r_wheel_radius <= i_cfg_data[30:0];
                CFG_LAT_KP:       r_lat_kp       <= i_cfg_data;
                CFG_LAT_KI:       r_lat_ki       <= i_cfg_data;
                CFG_LAT_KD:       r_lat_kd       <= i_cfg_data;
                CFG_HEADING_KP:   r_heading_kp   <= i_cfg_data;
                CFG_ARRIVE_DIST:  r_arrive_dist  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_integral <= '0;
            r_index    <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (s_acc) begin
                    r_dx   <= 33'(s_px) - 33'(s_tx);
                    r_dy   <= 33'(s_py) - 33'(s_ty);
                    r_eyaw <= s_pyaw - s_tyaw;
                    r_el   <= (s_el == '0) ? 16'd1 : s_el;
                    r_adv  <= 1'b0;
                    r_sat  <= 1'b0;
                    if (i_s_tuser[0]) begin
                        r_integral <= '0;
                        r_index    <= (s_sidx > IDX_LAST) ? IDX_LAST : s_sidx;
                        r_left     <= '0;
                        r_right    <= '0;
                    end
                end
                S_DYC:  r_acc <= prod;
                S_ELAT: begin
                    r_elat <= sat32(elat_full);
                    r_sat  <= r_sat | ovf32(elat_full);
                end
                S_EANG: r_eang <= pr16;
                S_PT:   r_w <= pr16;
                S_KI:   r_a <= pr16[47:0];
                S_AHI:  r_acc <= prod;
                S_INC: begin
                    r_integral <= sat32(isum);
                    r_sat      <= r_sat | ovf32(isum);
                end
                S_HT:   r_w <= r_w + pr16;
                S_DIVD: if (div_done) r_w <= wsum;
                S_WSAT: begin
                    r_wsat <= sat32(r_w);
                    r_sat  <= r_sat | ovf32(r_w);
                end
                S_LWC:  r_acc <= prod;
                S_DIVL: if (div_done) begin
                    r_left <= sat32(68'(quo));
                    r_sat  <= r_sat | ovf32(68'(quo));
                end
                S_DIVR: if (div_done) begin
                    r_right <= sat32(68'(quo));
                    r_sat   <= r_sat | ovf32(68'(quo));
                end
                S_UY:   r_acc <= prod;
                S_AD:   r_acc <= r_acc + prod;
                S_ADV: begin
                    r_adv <= !far && (r_acc < prod);
                    if (!far && (r_acc < prod) && (r_index < IDX_LAST)) begin
                        r_index <= r_index + 10'd1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
